@@ sv/rgbc_pkg.sv @@
// shared types and constants of the rgb 3x3 convolution block
`timescale 1ns / 1ps
package rgbc_pkg;
  localparam int MaxWidth  = 2048;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int FracBits  = 12;
  localparam int RowW      = 13;

  localparam logic [2:0] RegTop    = 3'd0;
  localparam logic [2:0] RegMid    = 3'd1;
  localparam logic [2:0] RegBot    = 3'd2;
  localparam logic [2:0] RegWidth  = 3'd3;
  localparam logic [2:0] RegHeight = 3'd4;

  localparam logic OpPixel = 1'b0;
  localparam logic OpFlush = 1'b1;

  // front to back: one window column plus position info
  typedef struct packed {
    logic [23:0] top;
    logic [23:0] mid;
    logic [23:0] bot;
    logic        emit;
    logic        vr0;
    logic        vr2;
    logic        vc0;
    logic        vc2;
    logic        last;
  } rgbc_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } rgbc_res_t;
endpackage

@@ sv/rgbc_if.sv @@
// valid/ready stream and config channel interfaces
`timescale 1ns / 1ps
interface rgbc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, op, red_in, green_in, blue_in, input ready);
  modport sink (input valid, op, red_in, green_in, blue_in, output ready);
endinterface

interface rgbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end;
  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface rgbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/rgbc_front.sv @@
// front end: line stores, position counters and item classification
`timescale 1ns / 1ps
module rgbc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [23:0]         in_pix,
  input  logic [11:0]         w_cfg,
  input  logic [12:0]         h_cfg,
  output logic                item_valid,
  input  logic                item_ready,
  output rgbc_pkg::rgbc_item_t item
);
  import rgbc_pkg::*;

  logic [23:0] older_mem [MaxWidth];
  logic [23:0] newer_mem [MaxWidth];

  logic [11:0] w;
  logic [12:0] h;
  logic [11:0] icol_r, icol_nxt, ocol_r, ocol_nxt;
  logic [RowW-1:0] irow_r, irow_nxt, orow_r, orow_nxt;
  logic [11:0] ic, oc;
  logic [RowW-1:0] ir, orr;
  logic        acc, primed, last;
  logic [23:0] pix;
  logic [ColW-1:0] addr;
  logic        s1_valid_r;
  logic [23:0] s1_pix_r, s1_top_r, s1_mid_r;
  rgbc_item_t  s1_item_r, s1_info;

  // clamped geometry
  always_comb begin
    w = (w_cfg < 12'd2) ? 12'd2 : ((w_cfg > 12'(MaxWidth)) ? 12'(MaxWidth) : w_cfg);
    h = (h_cfg < 13'd2) ? 13'd2 : h_cfg;
  end

  // stage 1 holds the read address stage; stall when downstream stalls
  assign in_ready = !s1_valid_r || item_ready;
  assign acc = in_valid && in_ready;

  // counters with pre-use wrap
  always_comb begin
    ic = icol_r; ir = irow_r;
    if (ic >= w) begin ic = 12'd0; ir = ir + 1'b1; end
    oc = ocol_r; orr = orow_r;
    if (oc >= w) begin oc = 12'd0; orr = orr + 1'b1; end
    pix = (in_op == OpFlush) ? 24'd0 : in_pix;
    primed = (ir >= 13'd2) || (ir == 13'd1 && ic >= 12'd1);
    last = ({1'b0, orr} + 14'd1 >= {1'b0, h}) && ({1'b0, oc} + 13'd1 >= {1'b0, w});
    icol_nxt = ic + 12'd1; irow_nxt = ir;
    if (icol_nxt >= w) begin icol_nxt = 12'd0; irow_nxt = ir + 1'b1; end
    ocol_nxt = oc; orow_nxt = orr;
    if (primed) begin
      ocol_nxt = oc + 12'd1;
      if (ocol_nxt >= w) begin ocol_nxt = 12'd0; orow_nxt = orr + 1'b1; end
    end
    if (primed && last) begin
      icol_nxt = 12'd0; irow_nxt = '0; ocol_nxt = 12'd0; orow_nxt = '0;
    end
    addr = ic[ColW-1:0];
    s1_info = '0;
    s1_info.emit = primed;
    s1_info.vr0 = orr != '0;
    s1_info.vr2 = {1'b0, orr} + 14'd1 < {1'b0, h};
    s1_info.vc0 = oc != 12'd0;
    s1_info.vc2 = {1'b0, oc} + 13'd1 < {1'b0, w};
    s1_info.last = last;
  end

  // position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icol_r <= '0; irow_r <= '0; ocol_r <= '0; orow_r <= '0; s1_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        icol_r <= icol_nxt; irow_r <= irow_nxt;
        ocol_r <= ocol_nxt; orow_r <= orow_nxt;
      end
      if (in_ready) s1_valid_r <= acc;
    end
  end

  // line stores: read old column, shift in new beat
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_top_r <= older_mem[addr];
      s1_mid_r <= newer_mem[addr];
      older_mem[addr] <= newer_mem[addr];
      newer_mem[addr] <= pix;
      s1_pix_r <= pix;
      s1_item_r <= s1_info;
    end
  end

  always_comb begin
    item      = s1_item_r;
    item.top  = s1_top_r;
    item.mid  = s1_mid_r;
    item.bot  = s1_pix_r;
  end
  assign item_valid = s1_valid_r;
endmodule

@@ sv/rgbc_back.sv @@
// back end: window shift, multiply-accumulate, clamp and output register
`timescale 1ns / 1ps
module rgbc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  rgbc_pkg::rgbc_item_t item,
  input  logic [47:0]          k_top,
  input  logic [47:0]          k_mid,
  input  logic [47:0]          k_bot,
  output logic                 res_valid,
  input  logic                 res_ready,
  output rgbc_pkg::rgbc_res_t  res
);
  import rgbc_pkg::*;

  logic [23:0] win_r [3][3];
  logic [47:0] krow [3];
  logic        p1_valid_r, p2_valid_r;
  logic        p1_last_r, p2_last_r;
  logic signed [24:0] prod_r [3][3][3];
  logic signed [28:0] sum_r [3];
  logic        stall, adv;
  logic        vr [3], vc [3];

  assign krow[0] = k_top; assign krow[1] = k_mid; assign krow[2] = k_bot;
  assign stall = res_valid && !res_ready;
  assign item_ready = !stall;
  assign adv = item_valid && !stall;

  always_comb begin
    vr[0] = item.vr0; vr[1] = 1'b1; vr[2] = item.vr2;
    vc[0] = item.vc0; vc[1] = 1'b1; vc[2] = item.vc2;
  end

  // window shift and products on new column
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= item.top;
      win_r[1][2] <= item.mid;
      win_r[2][2] <= item.bot;
      for (int ch = 0; ch < 3; ch++)
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) begin
            logic [23:0] px;
            px = (j == 2) ? ((i == 0) ? item.top : (i == 1) ? item.mid : item.bot)
                          : win_r[i][j+1];
            prod_r[ch][i][j] <= (vr[i] && vc[j])
              ? 25'($signed({1'b0, px[ch*8 +: 8]}) * $signed(krow[i][j*16 +: 16]))
              : 25'sd0;
          end
      p1_last_r <= item.last;
    end
    if (!stall) begin
      for (int ch = 0; ch < 3; ch++) begin
        logic signed [28:0] s;
        s = '0;
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) s = s + 29'(prod_r[ch][i][j]);
        sum_r[ch] <= s;
      end
      p2_last_r <= p1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0; p2_valid_r <= 1'b0;
    end else if (!stall) begin
      p1_valid_r <= adv && item.emit;
      p2_valid_r <= p1_valid_r;
    end
  end

  // truncate and clamp
  function automatic logic [7:0] clamp8(input logic signed [28:0] a);
    logic signed [28:0] q;
    q = a >>> FracBits;
    if (a <= 0) return 8'd0;
    else if (q > 29'sd255) return 8'd255;
    else return q[7:0];
  endfunction

  assign res_valid = p2_valid_r;
  assign res.red = clamp8(sum_r[0]);
  assign res.green = clamp8(sum_r[1]);
  assign res.blue = clamp8(sum_r[2]);
  assign res.frame_end = p2_last_r;
endmodule

@@ sv/rgb_conv3x3_zero_pad_unit.sv @@
// top level of the streaming rgb 3x3 convolution with zero padding
// channel | dir | beat
// in      | in  | op, red_in, green_in, blue_in
// out     | out | red_out, green_out, blue_out, frame_end
// cfg     | in  | index, data (kernel rows, width, height)
// one beat per clock sustained while the out channel is not stalled; the first W+1 beats of a frame give no result
// a result is registered through the front read stage, the product stage and the sum stage after its beat is accepted
// a stalled out channel holds the whole pipe; line stores keep no reset
// reset: counters zero, kernel identity, 1024x1024 frame
`timescale 1ns / 1ps
module rgb_conv3x3_zero_pad_unit (
  input logic clk,
  input logic rst_n,
  rgbc_in_if.sink    in_ch,
  rgbc_out_if.source out_ch,
  rgbc_cfg_if.sink   cfg_ch
);
  import rgbc_pkg::*;

  logic [47:0] k_top_r, k_mid_r, k_bot_r;
  logic [11:0] w_r;
  logic [12:0] h_r;
  logic        item_valid, item_ready;
  rgbc_item_t  item;
  rgbc_res_t   res;

  // config registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_top_r <= '0; k_mid_r <= 48'h0000_1000_0000; k_bot_r <= '0;
      w_r <= 12'd1024; h_r <= 13'd1024;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        RegTop:    k_top_r <= cfg_ch.data;
        RegMid:    k_mid_r <= cfg_ch.data;
        RegBot:    k_bot_r <= cfg_ch.data;
        RegWidth:  w_r <= cfg_ch.data[11:0];
        RegHeight: h_r <= cfg_ch.data[12:0];
        default: ;
      endcase
    end
  end

  rgbc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.op),
    .in_pix({in_ch.blue_in, in_ch.green_in, in_ch.red_in}),
    .w_cfg(w_r), .h_cfg(h_r),
    .item_valid(item_valid), .item_ready(item_ready), .item(item)
  );

  rgbc_back u_back (
    .clk(clk), .rst_n(rst_n),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .k_top(k_top_r), .k_mid(k_mid_r), .k_bot(k_bot_r),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
  );

  assign out_ch.red_out = res.red;
  assign out_ch.green_out = res.green;
  assign out_ch.blue_out = res.blue;
  assign out_ch.frame_end = res.frame_end;
endmodule

@@ tb/tb_rgb_conv3x3_zero_pad_unit.sv @@
// testbench for the rgb 3x3 convolution: directed and random frames checked against a scoreboard predictor
`timescale 1ns / 1ps
module tb_rgb_conv3x3_zero_pad_unit;
  import rgbc_pkg::*;

  localparam int StallMax  = 14;
  localparam int IdleLimit = 4000;
  localparam int Settle    = 12;

  // scoreboard: holds its own copy of the line stores and window
  class conv_scoreboard;
    logic [47:0] kern [3];
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    logic [23:0] older_ln [MaxWidth];
    logic [23:0] newer_ln [MaxWidth];
    logic [23:0] win [3][3];
    int          in_col, in_row, out_col, out_row;
    rgbc_res_t   pending [$];
    int          errors, beats_in, beats_out, frames;

    function new();
      kern[0] = '0;
      kern[1] = 48'h0000_1000_0000;
      kern[2] = '0;
      width_reg = 12'd1024;
      height_reg = 13'd1024;
      foreach (older_ln[i]) begin
        older_ln[i] = '0;
        newer_ln[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      errors = 0; beats_in = 0; beats_out = 0; frames = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] data);
      case (idx)
        RegTop:    kern[0] = data;
        RegMid:    kern[1] = data;
        RegBot:    kern[2] = data;
        RegWidth:  width_reg = data[11:0];
        RegHeight: height_reg = data[12:0];
        default: ;
      endcase
    endfunction

    // one channel: masked multiply-accumulate, truncate, clamp
    function logic [7:0] channel_sum(int sh, bit vr[3], bit vc[3]);
      longint acc;
      longint smp;
      longint coef;
      acc = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          if (vr[i] && vc[j]) begin
            smp  = longint'((win[i][j] >> sh) & 24'hFF);
            coef = longint'($signed(kern[i][16*j +: 16]));
            acc += smp * coef;
          end
      if (acc <= 0) return 8'd0;
      acc = acc >>> FracBits;
      return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    // an accepted input beat: shift the window and queue any result
    function void note_input(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int w, h;
      logic [23:0] pix;
      bit primed, last;
      bit vr[3], vc[3];
      rgbc_res_t res;
      beats_in++;
      w = int'(width_reg);
      h = int'(height_reg);
      if (w < 2) w = 2;
      if (w > MaxWidth) w = MaxWidth;
      if (h < 2) h = 2;
      if (in_col >= w) begin
        in_col = 0; in_row++;
      end
      if (out_col >= w) begin
        out_col = 0; out_row++;
      end
      pix = (op == OpFlush) ? 24'd0 : {b, g, r};
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = older_ln[in_col];
      win[1][2] = newer_ln[in_col];
      win[2][2] = pix;
      older_ln[in_col] = newer_ln[in_col];
      newer_ln[in_col] = pix;
      primed = in_row >= 2 || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
        in_col = 0; in_row++;
      end
      if (!primed) return;
      vr[0] = out_row != 0; vr[1] = 1'b1; vr[2] = out_row + 1 < h;
      vc[0] = out_col != 0; vc[1] = 1'b1; vc[2] = out_col + 1 < w;
      res.red = channel_sum(0, vr, vc);
      res.green = channel_sum(8, vr, vc);
      res.blue = channel_sum(16, vr, vc);
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.frame_end = last;
      pending.push_back(res);
      out_col++;
      if (out_col >= w) begin
        out_col = 0; out_row++;
      end
      if (last) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
    endfunction

    function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
      rgbc_res_t exp_res;
      beats_out++;
      if (pending.size() == 0) begin
        $error("unexpected result beat r=%0d g=%0d b=%0d end=%0b", r, g, b, fe);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (fe) frames++;
      if (r !== exp_res.red) begin
        $error("red_out expected %0d actual %0d", exp_res.red, r); errors++;
      end
      if (g !== exp_res.green) begin
        $error("green_out expected %0d actual %0d", exp_res.green, g); errors++;
      end
      if (b !== exp_res.blue) begin
        $error("blue_out expected %0d actual %0d", exp_res.blue, b); errors++;
      end
      if (fe !== exp_res.frame_end) begin
        $error("frame_end expected %0b actual %0b", exp_res.frame_end, fe); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   idle_cycles;
  conv_scoreboard sb;

  rgbc_in_if  in_if();
  rgbc_out_if out_if();
  rgbc_cfg_if cfg_if();

  rgb_conv3x3_zero_pad_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, StallMax);
  endfunction

  // one input beat with a random gap in front
  task automatic send_beat(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.op = op;
    in_if.red_in = r;
    in_if.green_in = g;
    in_if.blue_in = b;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(op, r, g, b);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [47:0] data);
    cfg_if.index = idx;
    cfg_if.data = data;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // hold the sender until every result is back and the pipe is empty
  task automatic drain_wait();
    in_if.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (Settle) @(negedge clk);
  endtask

  task automatic set_frame(logic [47:0] top, logic [47:0] mid, logic [47:0] bot,
                           logic [11:0] w, logic [12:0] h);
    drain_wait();
    cfg_write(RegTop, top);
    cfg_write(RegMid, mid);
    cfg_write(RegBot, bot);
    cfg_write(RegWidth, 48'(w));
    cfg_write(RegHeight, 48'(h));
  endtask

  // one frame of w x h pixels plus the w+1 drain beats
  task automatic run_frame(int w, int h, int hole_pct, bit extremes);
    logic [7:0] r, g, b;
    for (int i = 0; i < w * h; i++) begin
      r = extremes ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom);
      g = extremes ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom);
      b = extremes ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom);
      send_beat(($urandom_range(1, 100) <= hole_pct) ? OpFlush : OpPixel, r, g, b);
    end
    // drain beats: flushes, or pixels that fall past the frame
    for (int i = 0; i <= w; i++)
      send_beat($urandom_range(0, 1) ? OpFlush : OpPixel, 8'($urandom), 8'($urandom),
                8'($urandom));
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'd0;
      default: return 16'($signed($urandom_range(0, 6144)) - 2048);
    endcase
  endfunction

  function automatic logic [47:0] rand_row();
    return {rand_coef(), rand_coef(), rand_coef()};
  endfunction

  // receiver with random stalls
  initial begin
    int gap;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_if.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (!out_if.valid);
      sb.check_result(out_if.red_out, out_if.green_out, out_if.blue_out, out_if.frame_end);
      @(negedge clk);
    end
  end

  // watchdog on cycles with no beat on any channel
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int w, h;
    sb = new();
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OpPixel;
    in_if.red_in = '0;
    in_if.green_in = '0;
    in_if.blue_in = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = RegTop;
    cfg_if.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: width and height below range, most negative coefficients
    set_frame({3{16'h8000}}, 48'h0000_1000_0000, {3{16'h8000}}, 12'd1, 13'd0);
    run_frame(2, 2, 0, 1'b1);
    // largest coefficients, random black holes in about 30 percent of the beats
    set_frame({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 12'd3, 13'd1);
    run_frame(3, 2, 30, 1'b1);
    // identity with edge taps, each channel all-ones or all-zeros
    set_frame(48'h0000_0800_0000, 48'h0800_1000_0800, 48'h0000_0800_0000, 12'd2, 13'd2);
    run_frame(2, 2, 0, 1'b1);

    // a wide frame and a tall frame, no idling
    no_idle = 1'b1;
    set_frame(rand_row(), rand_row(), rand_row(), 12'd150, 13'd2);
    run_frame(150, 2, 5, 1'b0);
    set_frame(rand_row(), rand_row(), rand_row(), 12'd2, 13'd150);
    run_frame(2, 150, 5, 1'b0);
    no_idle = 1'b0;

    // random frames, mostly small
    while (sb.beats_in < 1250) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 8);
      h = $urandom_range(2, 6);
      no_idle = ($urandom_range(0, 5) == 0);
      set_frame(rand_row(), rand_row(), rand_row(), 12'(w), 13'(h));
      run_frame(w, h, $urandom_range(0, 1) ? 0 : 10, $urandom_range(0, 7) == 0);
    end
    no_idle = 1'b0;

    drain_wait();
    $display("covered %0d input beats, %0d result beats, %0d frames", sb.beats_in,
             sb.beats_out, sb.frames);
    $display("frame sizes from 2x2 up to 150 wide and 150 tall, kernel extremes and holes");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
